[rtl/rfp_pkg.sv]
// Shared types and constants for the RTP H.264 FU-A packetiser.
`timescale 1ns / 1ps
package rfp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PAYLOAD_TYPE = 3'd0;
  localparam logic [2:0] CFG_CLOCK_RATE   = 3'd1;
  localparam logic [2:0] CFG_MAX_PAYLOAD  = 3'd2;
  localparam logic [2:0] CFG_SOURCE_ID    = 3'd3;
  localparam logic [2:0] CFG_INIT_SEQ     = 3'd4;

  localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0]  FU_A_TYPE        = 8'd28;
  localparam logic [7:0]  NRI_MASK         = 8'hE0;
  localparam logic [7:0]  TYPE_MASK        = 8'h1F;
  localparam logic [7:0]  FU_START_BIT     = 8'h80;
  localparam logic [7:0]  FU_END_BIT       = 8'h40;

  // 1e9 = 2^9 * 5^9; the odd factor is divided out by reciprocal multiplication
  localparam logic [20:0] FIVE_POW9        = 21'd1953125;
  localparam logic [31:0] RECIP_5P9        = 32'd2305843009;  // floor(2^52 / 5^9)

  // Back-end byte steps: 0..11 RTP header, 12..13 FU bytes, 14 data
  localparam logic [3:0] STEP_FU_IND = 4'd12;
  localparam logic [3:0] STEP_FU_HDR = 4'd13;
  localparam logic [3:0] STEP_DATA   = 4'd14;

  // One classified NAL byte handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;      // open a packet with an RTP header
    logic        fu;       // follow the header with FU indicator and FU header
    logic        marker;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic        pend;     // this byte closes the packet
    logic [31:0] ts;
  } rfp_entry_t;

endpackage

[rtl/rfp_fifo.sv]
// Four-entry queue between the classifying front and the byte-emitting back.
`timescale 1ns / 1ps
module rfp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rfp_pkg::rfp_entry_t wdata_i,
  input  logic                pop_i,
  output rfp_pkg::rfp_entry_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);

  rfp_pkg::rfp_entry_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign rdata_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

endmodule

[rtl/rfp_front.sv]
// Front end: accepts NAL bytes, tracks NAL and fragment state, works out the timestamp.
`timescale 1ns / 1ps
module rfp_front #(
  parameter int unsigned MaxNalLength = 1048576,
  localparam int unsigned LenW = $clog2(MaxNalLength + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_start_i,
  input  logic                nal_start_i,
  input  logic                last_nal_of_frame_i,
  input  logic [LenW-1:0]     nal_length_i,
  input  logic [63:0]         capture_time_ns_i,
  input  logic [31:0]         frame_number_i,
  input  logic [31:0]         clock_rate_i,
  input  logic [15:0]         max_payload_i,
  output logic                push_o,
  output rfp_pkg::rfp_entry_t entry_o,
  input  logic                full_i,
  output logic                busy_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [5:0]  cnt_q;
  logic [63:0] acc_q, mcand_q;
  logic [54:0] dvd_q;
  logic [31:0] mplier_q, quo_q, n_q;
  logic [20:0] rem_q;
  logic [10:0] qe_q;
  logic [31:0] frame_ts_q;

  logic            open_q, frag_q;
  logic [LenW-1:0] off_q;
  logic [15:0]     fill_q;
  logic [7:0]      latch_q;

  rfp_pkg::rfp_entry_t entry_q;
  logic                entry_valid_q;

  logic accept;
  assign in_stall_o = (state_q != S_IDLE) || (entry_valid_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = entry_valid_q && (state_q == S_IDLE) && !full_i;
  assign entry_o    = entry_q;
  assign busy_o     = state_q != S_IDLE;

  // Classification of the byte on the input
  logic [31:0]     len32, off32, cap32, maxp32;
  logic [LenW-1:0] len;
  logic            open_e, frag_e, final_b, end_frag, pend, produce;
  logic [LenW-1:0] off_e;
  logic [15:0]     fill_e, fill_n;
  logic [7:0]      latch_e;
  rfp_pkg::rfp_entry_t ent;

  always_comb begin
    if (nal_length_i == '0) len = LenW'(1);
    else if (32'(nal_length_i) > MaxNalLength) len = LenW'(MaxNalLength);
    else len = nal_length_i;
    len32  = 32'(len);
    maxp32 = 32'(max_payload_i);
    cap32  = maxp32 - 32'd2;

    open_e  = nal_start_i ? 1'b1 : open_q;
    off_e   = nal_start_i ? '0 : off_q;
    fill_e  = nal_start_i ? '0 : fill_q;
    latch_e = nal_start_i ? data_byte_i : latch_q;
    frag_e  = nal_start_i ? (len32 > maxp32) : frag_q;
    off32   = 32'(off_e);

    final_b  = off32 + 32'd1 >= len32;
    end_frag = (len32 - off32) <= cap32;
    pend     = final_b;
    fill_n   = fill_e;
    produce  = 1'b0;

    ent.data   = data_byte_i;
    ent.hdr    = 1'b0;
    ent.fu     = 1'b0;
    ent.marker = last_nal_of_frame_i;
    ent.fu_ind = (latch_e & rfp_pkg::NRI_MASK) | rfp_pkg::FU_A_TYPE;
    ent.fu_hdr = ((off32 == 32'd1) ? rfp_pkg::FU_START_BIT : 8'h00)
               | (end_frag ? rfp_pkg::FU_END_BIT : 8'h00)
               | (latch_e & rfp_pkg::TYPE_MASK);
    ent.ts     = (frame_start_i && capture_time_ns_i == '0) ? frame_number_i : frame_ts_q;

    if (open_e && off32 < len32) begin
      if (!frag_e) begin
        produce = 1'b1;
        ent.hdr = off32 == 32'd0;
      end else if (off32 != 32'd0) begin
        produce    = 1'b1;
        ent.hdr    = fill_e == '0;
        ent.fu     = fill_e == '0;
        ent.marker = last_nal_of_frame_i && end_frag;
        pend       = final_b || (32'(fill_e) + 32'd1 >= cap32);
        fill_n     = pend ? '0 : fill_e + 16'd1;
      end
    end
    ent.pend = pend;
  end

  // NAL tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      frag_q  <= 1'b0;
      off_q   <= '0;
      fill_q  <= '0;
      latch_q <= '0;
    end else if (accept) begin
      frag_q  <= frag_e;
      latch_q <= latch_e;
      fill_q  <= fill_n;
      off_q   <= off_e;
      open_q  <= open_e;
      if (open_e) begin
        if (off32 >= len32) begin
          open_q <= 1'b0;
        end else begin
          off_q <= off_e + LenW'(1);
          if (final_b) open_q <= 1'b0;
        end
      end
    end
  end

  // Entry holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (accept) begin
      entry_valid_q <= produce;
    end else if (push_o) begin
      entry_valid_q <= 1'b0;
    end
  end

  // Timestamp sequencer: shift-add multiply, then the product is shifted down by nine
  // and divided by 5^9 in five base-2^11 digits; each digit is estimated by reciprocal
  // multiplication and corrected once, an estimate step followed by a correction step
  logic [63:0] acc_n;
  logic [31:0] div_n, r_est, r_fix;
  logic [63:0] div_prod;
  logic [10:0] q_fix;
  logic        r_ge;
  assign acc_n    = acc_q + (mplier_q[0] ? mcand_q : 64'd0);
  assign div_n    = {rem_q, dvd_q[54:44]};
  assign div_prod = 64'(div_n) * 64'(rfp_pkg::RECIP_5P9);
  assign r_est    = n_q - 32'(qe_q) * 32'(rfp_pkg::FIVE_POW9);
  assign r_ge     = r_est >= 32'(rfp_pkg::FIVE_POW9);
  assign q_fix    = qe_q + {10'd0, r_ge};
  assign r_fix    = r_ge ? r_est - 32'(rfp_pkg::FIVE_POW9) : r_est;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && frame_start_i && capture_time_ns_i != '0) state_d = S_MUL;
      S_MUL:   if (cnt_q == 6'd31) state_d = S_DIV;
      S_DIV:   if (cnt_q == 6'd9) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      frame_ts_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (accept && frame_start_i && capture_time_ns_i == '0) frame_ts_q <= frame_number_i;
        end
        S_MUL:   cnt_q <= (cnt_q == 6'd31) ? 6'd0 : cnt_q + 6'd1;
        S_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd9) frame_ts_q <= {quo_q[20:0], q_fix};
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  // Datapath of the sequencer and entry payload
  always_ff @(posedge clk_i) begin
    if (accept) entry_q <= ent;
    unique case (state_q)
      S_IDLE: begin
        acc_q    <= '0;
        mcand_q  <= capture_time_ns_i;
        mplier_q <= clock_rate_i;
      end
      S_MUL: begin
        acc_q    <= acc_n;
        mcand_q  <= {mcand_q[62:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[31:1]};
        if (cnt_q == 6'd31) begin
          dvd_q <= acc_n[63:9];
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      S_DIV: begin
        if (!cnt_q[0]) begin
          // digit estimate from the reciprocal
          qe_q  <= div_prod[62:52];
          n_q   <= div_n;
          dvd_q <= {dvd_q[43:0], 11'd0};
        end else begin
          // correct the estimate by at most one
          rem_q <= r_fix[20:0];
          quo_q <= {quo_q[20:0], q_fix};
          if (cnt_q == 6'd9) entry_q.ts <= {quo_q[20:0], q_fix};
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/rfp_back.sv]
// Back end: expands queued entries into RTP packet bytes through an output register.
`timescale 1ns / 1ps
module rfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfp_pkg::rfp_entry_t entry_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  logic [6:0]          payload_type_i,
  input  logic [31:0]         source_id_i,
  input  logic                seq_load_i,
  input  logic [15:0]         seq_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                packet_end_o
);

  rfp_pkg::rfp_entry_t cur_q;
  logic       active_q;
  logic [3:0] step_q;
  logic [15:0] seq_q;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       oend_q;

  logic advance, emit;
  assign advance = !ovalid_q || !out_stall_i;
  assign emit    = active_q && advance;
  assign pop_o   = !active_q && !empty_i;

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign packet_end_o = oend_q;

  // byte for the current step
  logic [7:0] b;
  always_comb begin
    unique case (step_q)
      4'd0:  b = rfp_pkg::RTP_VERSION_BYTE;
      4'd1:  b = {cur_q.marker, payload_type_i};
      4'd2:  b = seq_q[15:8];
      4'd3:  b = seq_q[7:0];
      4'd4:  b = cur_q.ts[31:24];
      4'd5:  b = cur_q.ts[23:16];
      4'd6:  b = cur_q.ts[15:8];
      4'd7:  b = cur_q.ts[7:0];
      4'd8:  b = source_id_i[31:24];
      4'd9:  b = source_id_i[23:16];
      4'd10: b = source_id_i[15:8];
      4'd11: b = source_id_i[7:0];
      rfp_pkg::STEP_FU_IND: b = cur_q.fu_ind;
      rfp_pkg::STEP_FU_HDR: b = cur_q.fu_hdr;
      default: b = cur_q.data;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= entry_i;
    if (emit) begin
      obyte_q <= b;
      oend_q  <= (step_q == rfp_pkg::STEP_DATA) && cur_q.pend;
    end
  end

  // step sequencing, sequence counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      seq_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (seq_load_i) seq_q <= seq_value_i;
      if (pop_o) begin
        active_q <= 1'b1;
        step_q   <= entry_i.hdr ? 4'd0 : rfp_pkg::STEP_DATA;
      end else if (emit) begin
        priority if (step_q == rfp_pkg::STEP_DATA) active_q <= 1'b0;
        else if (step_q == 4'd11) step_q <= cur_q.fu ? rfp_pkg::STEP_FU_IND : rfp_pkg::STEP_DATA;
        else step_q <= step_q + 4'd1;
        if (step_q == 4'd3) seq_q <= seq_q + 16'd1;
      end
      if (advance) ovalid_q <= emit;
    end
  end

endmodule

[rtl/rtp_h264_fua_packetizer.sv]
// Top level of the RTP H.264 FU-A packetiser: registers, front, queue, back.
`timescale 1ns / 1ps
// One NAL byte is taken per cycle unless stalled and gives zero to fifteen output beats, emitted
// one per cycle by the back end unless out_stall is high; the input keeps flowing while the
// four-deep queue has room, so the back end sets the sustained rate: it loads each queued entry
// and then emits its header bytes, if any, and its payload byte. Frame_start with a nonzero
// capture time stalls the input while the timestamp is formed by a 32-step shift-add multiply
// and a division by 1e9 (shift by nine, then five reciprocal digits by 5^9).
module rtp_h264_fua_packetizer #(
  parameter int unsigned MaxNalLength = 1048576,
  localparam int unsigned LenW = $clog2(MaxNalLength + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            frame_start_i,
  input  logic            nal_start_i,
  input  logic            last_nal_of_frame_i,
  input  logic [LenW-1:0] nal_length_i,
  input  logic [63:0]     capture_time_ns_i,
  input  logic [31:0]     frame_number_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            packet_end_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i
);

  logic [6:0]  payload_type_q;
  logic [31:0] clock_rate_q, source_id_q;
  logic [15:0] max_payload_q;
  logic        cfg_wr, seq_load;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign seq_load    = cfg_wr && (cfg_index_i == rfp_pkg::CFG_INIT_SEQ);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_type_q <= 7'd96;
      clock_rate_q   <= 32'd90000;
      max_payload_q  <= 16'd1400;
      source_id_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        rfp_pkg::CFG_PAYLOAD_TYPE: payload_type_q <= cfg_data_i[6:0];
        rfp_pkg::CFG_CLOCK_RATE:   clock_rate_q   <= cfg_data_i;
        rfp_pkg::CFG_MAX_PAYLOAD:
          max_payload_q <= (cfg_data_i[15:0] < 16'd3) ? 16'd3 : cfg_data_i[15:0];
        rfp_pkg::CFG_SOURCE_ID:    source_id_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rfp_pkg::rfp_entry_t push_entry, pop_entry;
  logic push, pop, full, empty, ts_busy;

  rfp_front #(.MaxNalLength(MaxNalLength)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .frame_start_i,
    .nal_start_i, .last_nal_of_frame_i, .nal_length_i, .capture_time_ns_i,
    .frame_number_i,
    .clock_rate_i (clock_rate_q),
    .max_payload_i(max_payload_q),
    .push_o       (push),
    .entry_o      (push_entry),
    .full_i       (full),
    .busy_o       (ts_busy)
  );

  rfp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push), .wdata_i(push_entry), .pop_i(pop), .rdata_o(pop_entry),
    .full_o (full), .empty_o(empty)
  );

  rfp_back u_back (
    .clk_i, .rst_ni,
    .entry_i       (pop_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .payload_type_i(payload_type_q),
    .source_id_i   (source_id_q),
    .seq_load_i    (seq_load),
    .seq_value_i   (cfg_data_i[15:0]),
    .out_valid_o, .out_stall_i, .out_byte_o, .packet_end_o
  );

  // queue never written when full nor read when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !push)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty |-> !pop)
    else $error("queue underflow");
  // input held while the timestamp is being worked out
  assert property (@(posedge clk_i) disable iff (!rst_ni) ts_busy |-> in_stall_o)
    else $error("input taken during timestamp calculation");

endmodule
